[hw/rtl/mcst_pkg.sv]
`timescale 1ns / 1ps

package mcst_pkg;

  localparam int unsigned CHANNELS = 16;
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned STATUS_W = 8;
  localparam int unsigned DATA_W   = 7;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned PARAM_W  = 4;
  localparam int unsigned VALUE_W  = 14;
  localparam int unsigned RPN_W    = 14;
  localparam int unsigned WORD_W   = 16;

  localparam logic [RPN_W-1:0] RPN_RESET = '1;

  // upper nibble of the status byte
  localparam logic [3:0] KIND_CTRL    = 4'hB;
  localparam logic [3:0] KIND_PROGRAM = 4'hC;
  localparam logic [3:0] KIND_BEND    = 4'hE;

  // controller numbers
  localparam logic [DATA_W-1:0] CC_MOD        = 7'd1;
  localparam logic [DATA_W-1:0] CC_DATA_MSB   = 7'd6;
  localparam logic [DATA_W-1:0] CC_VOLUME     = 7'd7;
  localparam logic [DATA_W-1:0] CC_PAN        = 7'd10;
  localparam logic [DATA_W-1:0] CC_DATA_LSB   = 7'd38;
  localparam logic [DATA_W-1:0] CC_PEDAL      = 7'd64;
  localparam logic [DATA_W-1:0] CC_REVERB     = 7'd91;
  localparam logic [DATA_W-1:0] CC_CHORUS     = 7'd93;
  localparam logic [DATA_W-1:0] CC_DATA_INC   = 7'd96;
  localparam logic [DATA_W-1:0] CC_DATA_DEC   = 7'd97;
  localparam logic [DATA_W-1:0] CC_NRPN_LSB   = 7'd98;
  localparam logic [DATA_W-1:0] CC_NRPN_MSB   = 7'd99;
  localparam logic [DATA_W-1:0] CC_RPN_LSB    = 7'd100;
  localparam logic [DATA_W-1:0] CC_RPN_MSB    = 7'd101;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_RPN  = 2'd1,
    SEL_NRPN = 2'd2
  } sel_e;

  typedef enum logic [PARAM_W-1:0] {
    PARAM_PROGRAM = 4'd0,
    PARAM_VOLUME  = 4'd1,
    PARAM_PAN     = 4'd2,
    PARAM_BEND    = 4'd3,
    PARAM_RANGE   = 4'd4,
    PARAM_MOD     = 4'd5,
    PARAM_REVERB  = 4'd6,
    PARAM_CHORUS  = 4'd7,
    PARAM_PEDAL   = 4'd8
  } param_e;

  typedef struct packed {
    logic [RPN_W-1:0]  rpn_number;
    logic              rpn_lsb_seen;
    logic              rpn_msb_seen;
    logic              nrpn_lsb_seen;
    logic              nrpn_msb_seen;
    sel_e              last_selected;
    logic [WORD_W-1:0] bend_range_word;
  } chan_state_t;

  localparam chan_state_t CHAN_STATE_RESET = '{
    rpn_number:      RPN_RESET,
    rpn_lsb_seen:    1'b0,
    rpn_msb_seen:    1'b0,
    nrpn_lsb_seen:   1'b0,
    nrpn_msb_seen:   1'b0,
    last_selected:   SEL_NONE,
    bend_range_word: '0
  };

  typedef struct packed {
    logic [STATUS_W-1:0] status_byte;
    logic [DATA_W-1:0]   data_first;
    logic [DATA_W-1:0]   data_second;
  } msg_t;

  typedef struct packed {
    logic               has_update;
    logic [CHAN_W-1:0]  channel;
    param_e             which_param;
    logic [VALUE_W-1:0] value;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] idx;
    chan_state_t         data;
  } state_wr_t;

endpackage

[hw/rtl/mcst_state.sv]
`timescale 1ns / 1ps

module mcst_state (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mcst_pkg::CH_IDX_W-1:0]     rd_idx_i,
  output mcst_pkg::chan_state_t             rd_data_o,
  input  mcst_pkg::state_wr_t               wr_i
);

  mcst_pkg::chan_state_t entry_q [mcst_pkg::CHANNELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < mcst_pkg::CHANNELS; i++) begin
        entry_q[i] <= mcst_pkg::CHAN_STATE_RESET;
      end
    end else if (wr_i.en) begin
      entry_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign rd_data_o = entry_q[rd_idx_i];

endmodule

[hw/rtl/mcst_decode.sv]
`timescale 1ns / 1ps

module mcst_decode (
  input  mcst_pkg::msg_t                    msg_i,
  input  logic                              fire_i,
  output logic [mcst_pkg::CH_IDX_W-1:0]     rd_idx_o,
  input  mcst_pkg::chan_state_t             cur_i,
  output mcst_pkg::state_wr_t               wr_o,
  output mcst_pkg::result_t                 res_o
);

  logic [3:0]                    kind;
  logic [mcst_pkg::CHAN_W-1:0]   chan;
  logic [mcst_pkg::DATA_W-1:0]   d1;
  logic [mcst_pkg::DATA_W-1:0]   d2;
  logic                          ch_ok;
  logic                          bend_sel;
  logic                          data_ctl;
  logic                          sel_ctl;
  mcst_pkg::chan_state_t         nxt;

  assign kind  = msg_i.status_byte[7:4];
  assign chan  = msg_i.status_byte[3:0];
  assign d1    = msg_i.data_first;
  assign d2    = msg_i.data_second;
  assign ch_ok = ({1'b0, chan} < 5'(mcst_pkg::CHANNELS));

  assign rd_idx_o = mcst_pkg::CH_IDX_W'(chan);
  assign bend_sel = (cur_i.last_selected == mcst_pkg::SEL_RPN) && (cur_i.rpn_number == '0);

  always_comb begin
    nxt      = cur_i;
    data_ctl = 1'b0;
    sel_ctl  = 1'b0;
    res_o.has_update  = 1'b0;
    res_o.channel     = chan;
    res_o.which_param = mcst_pkg::PARAM_PROGRAM;
    res_o.value       = '0;

    if (ch_ok) begin
      case (kind)
        mcst_pkg::KIND_PROGRAM: begin
          res_o.has_update  = 1'b1;
          res_o.which_param = mcst_pkg::PARAM_PROGRAM;
          res_o.value       = {7'd0, d1};
        end
        mcst_pkg::KIND_BEND: begin
          res_o.has_update  = 1'b1;
          res_o.which_param = mcst_pkg::PARAM_BEND;
          res_o.value       = {d2, d1};
        end
        mcst_pkg::KIND_CTRL: begin
          res_o.value = {7'd0, d2};
          case (d1)
            mcst_pkg::CC_VOLUME: begin
              res_o.has_update  = 1'b1;
              res_o.which_param = mcst_pkg::PARAM_VOLUME;
            end
            mcst_pkg::CC_PAN: begin
              res_o.has_update  = 1'b1;
              res_o.which_param = mcst_pkg::PARAM_PAN;
            end
            mcst_pkg::CC_MOD: begin
              res_o.has_update  = 1'b1;
              res_o.which_param = mcst_pkg::PARAM_MOD;
            end
            mcst_pkg::CC_REVERB: begin
              res_o.has_update  = 1'b1;
              res_o.which_param = mcst_pkg::PARAM_REVERB;
            end
            mcst_pkg::CC_CHORUS: begin
              res_o.has_update  = 1'b1;
              res_o.which_param = mcst_pkg::PARAM_CHORUS;
            end
            mcst_pkg::CC_PEDAL: begin
              res_o.has_update  = 1'b1;
              res_o.which_param = mcst_pkg::PARAM_PEDAL;
            end
            mcst_pkg::CC_NRPN_MSB: begin
              sel_ctl = 1'b1;
              nxt.nrpn_msb_seen = 1'b1;
              nxt.last_selected = cur_i.nrpn_lsb_seen ? mcst_pkg::SEL_NRPN : mcst_pkg::SEL_NONE;
            end
            mcst_pkg::CC_NRPN_LSB: begin
              sel_ctl = 1'b1;
              nxt.nrpn_lsb_seen = 1'b1;
              nxt.last_selected = cur_i.nrpn_msb_seen ? mcst_pkg::SEL_NRPN : mcst_pkg::SEL_NONE;
            end
            mcst_pkg::CC_RPN_MSB: begin
              sel_ctl = 1'b1;
              nxt.rpn_number[13:7] = d2;
              nxt.rpn_msb_seen     = 1'b1;
              nxt.last_selected = cur_i.rpn_lsb_seen ? mcst_pkg::SEL_RPN : mcst_pkg::SEL_NONE;
            end
            mcst_pkg::CC_RPN_LSB: begin
              sel_ctl = 1'b1;
              nxt.rpn_number[6:0] = d2;
              nxt.rpn_lsb_seen    = 1'b1;
              nxt.last_selected = cur_i.rpn_msb_seen ? mcst_pkg::SEL_RPN : mcst_pkg::SEL_NONE;
            end
            mcst_pkg::CC_DATA_MSB: begin
              data_ctl = 1'b1;
              nxt.bend_range_word = {2'b00, d2, cur_i.bend_range_word[6:0]};
            end
            mcst_pkg::CC_DATA_LSB: begin
              data_ctl = 1'b1;
              nxt.bend_range_word = {2'b00, cur_i.bend_range_word[13:7], d2};
            end
            mcst_pkg::CC_DATA_INC: begin
              data_ctl = 1'b1;
              nxt.bend_range_word = cur_i.bend_range_word + {9'd0, d2};
            end
            mcst_pkg::CC_DATA_DEC: begin
              data_ctl = 1'b1;
              nxt.bend_range_word = cur_i.bend_range_word - {9'd0, d2};
            end
            default: begin
              res_o.value = '0;
            end
          endcase
          if (data_ctl && bend_sel) begin
            res_o.has_update  = 1'b1;
            res_o.which_param = mcst_pkg::PARAM_RANGE;
            res_o.value       = {7'd0, nxt.bend_range_word[13:7]};
          end else if (!res_o.has_update) begin
            res_o.value = '0;
          end
        end
        default: begin
          res_o.has_update = 1'b0;
        end
      endcase
    end
  end

  assign wr_o.en   = fire_i && ch_ok && (kind == mcst_pkg::KIND_CTRL)
                     && (sel_ctl || (data_ctl && bend_sel));
  assign wr_o.idx  = rd_idx_o;
  assign wr_o.data = nxt;

endmodule

[hw/rtl/midi_channel_state_tracker_core.sv]
`timescale 1ns / 1ps

// channel | direction | beat payload
// in      | sink      | status_byte_i, data_first_i, data_second_i
// out     | source    | has_update_o, channel_o, which_param_o, value_o
//
// one beat per cycle sustained while out_ready_i is high; each beat passes the
// input register, then per-channel read-modify-write into the result register
// state of a beat is written as it moves to the result register, so the next
// beat sees it
// reset clears all channel state at once, no sweep
// a stalled result holds both stages; in_ready_o drops only when both are full

module midi_channel_state_tracker_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mcst_pkg::STATUS_W-1:0]     status_byte_i,
  input  logic [mcst_pkg::DATA_W-1:0]       data_first_i,
  input  logic [mcst_pkg::DATA_W-1:0]       data_second_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              has_update_o,
  output logic [mcst_pkg::CHAN_W-1:0]       channel_o,
  output logic [mcst_pkg::PARAM_W-1:0]      which_param_o,
  output logic [mcst_pkg::VALUE_W-1:0]      value_o
);

  logic                              in_valid_q;
  mcst_pkg::msg_t                    msg_q;
  logic                              out_valid_q;
  mcst_pkg::result_t                 res_q;
  mcst_pkg::result_t                 res_d;
  logic                              out_free;
  logic                              advance;
  logic [mcst_pkg::CH_IDX_W-1:0]     rd_idx;
  mcst_pkg::chan_state_t             cur;
  mcst_pkg::state_wr_t               wr;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      msg_q <= '{status_byte: status_byte_i, data_first: data_first_i,
                 data_second: data_second_i};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  mcst_decode u_decode (
    .msg_i    (msg_q),
    .fire_i   (advance),
    .rd_idx_o (rd_idx),
    .cur_i    (cur),
    .wr_o     (wr),
    .res_o    (res_d)
  );

  mcst_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .rd_data_o (cur),
    .wr_i      (wr)
  );

  assign out_valid_o   = out_valid_q;
  assign has_update_o  = res_q.has_update;
  assign channel_o     = res_q.channel;
  assign which_param_o = res_q.which_param;
  assign value_o       = res_q.value;

  a_no_update_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_update_o |-> (which_param_o == mcst_pkg::PARAM_PROGRAM)
      && (value_o == '0))
    else $error("result without update carries a value");

  a_narrow_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (which_param_o != mcst_pkg::PARAM_BEND) |-> (value_o[13:7] == '0))
    else $error("seven-bit parameter has high value bits set");

  a_state_write_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> advance)
    else $error("channel state written without a beat moving");

  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(msg_q))
    else $error("input stage lost a stalled beat");

endmodule
